[design/frp_pkg.sv]
// Shared types and constants for the sync-framed packet receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package frp_pkg;

  localparam logic [31:0] SYNC_WORD    = 32'haa5555aa;
  localparam logic [31:0] TRAILER_WORD = 32'h1a0aa55a;
  localparam logic [7:0]  SUM_MASK     = 8'hff;
  localparam logic [15:0] MIN_LENGTH   = 16'd5;
  localparam logic [15:0] WORD_BYTES   = 16'd4;

  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_HEADER   = 3'd1,
    PH_PAYLOAD  = 3'd2,
    PH_CHECKSUM = 3'd3,
    PH_TRAILER  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    K_HEADER  = 3'd0,
    K_PAYLOAD = 3'd1,
    K_GOOD    = 3'd2,
    K_CSUMBAD = 3'd3,
    K_TRLBAD  = 3'd4,
    K_SHORT   = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] opcode;
    logic [15:0] length;
    logic [7:0]  data;
    logic [15:0] index;
  } result_t;

endpackage

`default_nettype wire

[design/sync_framed_packet_receiver_top.sv]
// Sync-framed packet receiver: one received byte per request; each result is
// registered in the output stage; takes one byte per cycle while in_ready is high.
// A two-entry output stage (result register plus skid) holds in_ready low only
// while both entries wait. Synchronous active-low reset returns the parser to
// sync hunting, clears all parser state, the checksum mode and the output stage.
`default_nettype none

module sync_framed_packet_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_result_kind,
  output logic [15:0]      out_frame_opcode,
  output logic [15:0]      out_frame_length,
  output logic [7:0]       out_data_byte,
  output logic [15:0]      out_payload_index
);
  import frp_pkg::*;

  logic    take;
  logic    res_valid;
  result_t res;
  result_t out_data;

  assign take = in_valid && in_ready;

  frp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  frp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take && res_valid),
    .push_data (res),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_result_kind   = out_data.kind;
  assign out_frame_opcode  = out_data.opcode;
  assign out_frame_length  = out_data.length;
  assign out_data_byte     = out_data.data;
  assign out_payload_index = out_data.index;

endmodule

`default_nettype wire

[design/frp_parser.sv]
// Frame parser: sync hunt, header, payload, checksum and trailer phases.
// Depends on frp_pkg; produces at most one result per accepted byte.
`default_nettype none

module frp_parser (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic           cfg_wdata,
  input  wire logic           take,
  input  wire logic [7:0]     rx_byte,
  output logic                res_valid,
  output frp_pkg::result_t    res
);
  import frp_pkg::*;

  phase_t      phase_r,  phase_nxt;
  logic [31:0] recent_r, recent_nxt;
  logic [15:0] cnt_r,    cnt_nxt;
  logic [15:0] opcode_r, opcode_nxt;
  logic [15:0] length_r, length_nxt;
  logic [7:0]  sum_r,    sum_nxt;
  logic        csum_inv_r;

  logic [31:0] shifted;
  logic [15:0] cnt_inc;
  logic [7:0]  sum_add;
  logic [7:0]  expect_sum;

  assign shifted    = {rx_byte, recent_r[31:8]};
  assign cnt_inc    = cnt_r + 16'd1;
  assign sum_add    = sum_r + rx_byte;
  assign expect_sum = csum_inv_r ? (sum_r ^ SUM_MASK) : sum_r;

  always_comb begin
    phase_nxt  = phase_r;
    recent_nxt = recent_r;
    cnt_nxt    = cnt_r;
    opcode_nxt = opcode_r;
    length_nxt = length_r;
    sum_nxt    = sum_r;
    res_valid  = 1'b0;
    res.kind   = K_HEADER;
    res.data   = 8'd0;
    res.index  = 16'd0;
    unique case (phase_r)
      PH_HEADER: begin
        sum_nxt    = sum_add;
        recent_nxt = shifted;
        cnt_nxt    = cnt_inc;
        if (cnt_inc >= WORD_BYTES) begin
          opcode_nxt = shifted[15:0];
          length_nxt = shifted[31:16];
          recent_nxt = 32'd0;
          cnt_nxt    = 16'd0;
          res_valid  = 1'b1;
          if (shifted[31:16] < MIN_LENGTH) begin
            phase_nxt = PH_HUNT;
            res.kind  = K_SHORT;
          end else begin
            phase_nxt = (shifted[31:16] == MIN_LENGTH) ? PH_CHECKSUM : PH_PAYLOAD;
            res.kind  = K_HEADER;
          end
        end
      end
      PH_PAYLOAD: begin
        sum_nxt   = sum_add;
        res_valid = 1'b1;
        res.kind  = K_PAYLOAD;
        res.data  = rx_byte;
        res.index = cnt_r;
        cnt_nxt   = cnt_inc;
        if (cnt_inc == length_r - MIN_LENGTH) begin
          cnt_nxt   = 16'd0;
          phase_nxt = PH_CHECKSUM;
        end
      end
      PH_CHECKSUM: begin
        // The sum register keeps the mismatch; zero means the checksum matched.
        sum_nxt    = expect_sum ^ rx_byte;
        recent_nxt = 32'd0;
        cnt_nxt    = 16'd0;
        phase_nxt  = PH_TRAILER;
      end
      PH_TRAILER: begin
        recent_nxt = shifted;
        cnt_nxt    = cnt_inc;
        if (cnt_inc >= WORD_BYTES) begin
          res_valid = 1'b1;
          priority if (sum_r != 8'd0) begin
            res.kind = K_CSUMBAD;
          end else if (shifted != TRAILER_WORD) begin
            res.kind = K_TRLBAD;
          end else begin
            res.kind = K_GOOD;
          end
          recent_nxt = 32'd0;
          cnt_nxt    = 16'd0;
          phase_nxt  = PH_HUNT;
        end
      end
      default: begin
        recent_nxt = shifted;
        phase_nxt  = PH_HUNT;
        if (shifted == SYNC_WORD) begin
          recent_nxt = 32'd0;
          cnt_nxt    = 16'd0;
          sum_nxt    = 8'd0;
          phase_nxt  = PH_HEADER;
        end
      end
    endcase
    res.opcode = opcode_nxt;
    res.length = length_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      recent_r   <= 32'd0;
      cnt_r      <= 16'd0;
      opcode_r   <= 16'd0;
      length_r   <= 16'd0;
      sum_r      <= 8'd0;
      csum_inv_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        csum_inv_r <= cfg_wdata;
      end
      if (take) begin
        phase_r  <= phase_nxt;
        recent_r <= recent_nxt;
        cnt_r    <= cnt_nxt;
        opcode_r <= opcode_nxt;
        length_r <= length_nxt;
        sum_r    <= sum_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[design/frp_out_buf.sv]
// Result register with a skid stage, so a byte can be taken while a result waits.
// Depends on frp_pkg for the result type.
`default_nettype none

module frp_out_buf (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire frp_pkg::result_t push_data,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output frp_pkg::result_t      out_data
);
  import frp_pkg::*;

  logic    main_v_r;
  logic    skid_v_r;
  result_t main_r;
  result_t skid_r;
  logic    pop;

  assign pop       = main_v_r && out_ready;
  assign room      = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      // No request is taken while the skid stage is full.
      if (pop) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (push && (!main_v_r || pop)) begin
      main_v_r <= 1'b1;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push && (!main_v_r || pop)) begin
      main_r <= push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

`default_nettype wire

[design/frp_checker.sv]
// Port-level checks for the sync-framed packet receiver.
// Depends on frp_pkg; bound to sync_framed_packet_receiver_top below.
`default_nettype none

module frp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_result_kind,
  input wire logic [7:0]  out_data_byte,
  input wire logic [15:0] out_payload_index
);
  import frp_pkg::*;

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind)
      && $stable(out_data_byte) && $stable(out_payload_index))
    else $error("stalled result changed");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_kind <= K_SHORT)
    else $error("result kind out of range");

  // Only payload results carry a data byte and an index.
  a_nonpayload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != K_PAYLOAD |->
      out_data_byte == 8'd0 && out_payload_index == 16'd0)
    else $error("non-payload result carries data");

  // Backpressure on the input only when a result is already waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output stage not empty after reset");

endmodule

bind sync_framed_packet_receiver_top frp_checker u_frp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_result_kind   (out_result_kind),
  .out_data_byte     (out_data_byte),
  .out_payload_index (out_payload_index)
);

`default_nettype wire
